// ===== src/sde_pkg.sv =====
package sde_pkg;

  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_EOM  = 1'b1;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QUOTE = 8'h3E;

  // keyword "From " is five bytes, at most four are ever held
  localparam int KEY_LEN = 5;
  localparam logic [2:0] KEY_HELD_MAX = 3'(KEY_LEN - 1);

  // command queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } sde_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } sde_out_t;

  typedef enum logic [1:0] {
    LM_START  = 2'd0,
    LM_MIDDLE = 2'd1,
    LM_KEY    = 2'd2
  } line_mode_t;

  typedef enum logic [2:0] {
    TAIL_NONE = 3'd0,
    TAIL_CRLF = 3'd1,
    TAIL_DOTS = 3'd2,
    TAIL_BYTE = 3'd3,
    TAIL_FROM = 3'd4
  } tail_t;

  // one queued command: held keyword prefix, then a tail sequence
  typedef struct packed {
    logic [2:0] held;
    tail_t      tail;
    logic [7:0] data;
  } sde_cmd_t;

  function automatic logic [7:0] key_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = 8'h46;  // F
      3'd1: r = 8'h72;  // r
      3'd2: r = 8'h6F;  // o
      3'd3: r = 8'h6D;  // m
      3'd4: r = 8'h20;  // space
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] tail_len(input tail_t t);
    logic [2:0] r;
    case (t)
      TAIL_NONE: r = 3'd0;
      TAIL_CRLF: r = 3'd2;
      TAIL_DOTS: r = 3'd2;
      TAIL_BYTE: r = 3'd1;
      TAIL_FROM: r = 3'd6;
      default:   r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] cmd_len(input sde_cmd_t c);
    return c.held + tail_len(c.tail);
  endfunction

  function automatic logic [7:0] cmd_byte(input sde_cmd_t c, input logic [2:0] idx);
    logic [7:0] r;
    logic [2:0] j;
    j = idx - c.held;
    if (idx < c.held) begin
      r = key_char(idx);
    end else begin
      case (c.tail)
        TAIL_CRLF: r = (j == 3'd0) ? CH_CR : CH_LF;
        TAIL_DOTS: r = CH_DOT;
        TAIL_BYTE: r = c.data;
        TAIL_FROM: r = (j == 3'd0) ? CH_QUOTE : key_char(j - 3'd1);
        default:   r = 8'h00;
      endcase
    end
    return r;
  endfunction

  // number of prefix bytes held, kept within 1..4
  function automatic logic [2:0] held_count(input logic [2:0] m);
    logic [2:0] r;
    r = m;
    if (m < 3'd1) r = 3'd1;
    if (m > KEY_HELD_MAX) r = KEY_HELD_MAX;
    return r;
  endfunction

endpackage

// ===== src/smtp_data_transparency_encoder.sv =====
// SMTP DATA body encoder: turns LF into CR LF, doubles a leading dot and
// escapes a leading "From " as ">From ", holding a partial keyword back until
// it matches or breaks. One input transaction is accepted per cycle while the
// four-entry command queue has room; each transaction yields 0 to 6 output
// bytes, sent one per cycle, unless out_ready stalls, from a registered
// output, so the sustained input rate is set by the single output sequencer.
// At end of message a held prefix is flushed and an open line ends in CR LF.
// Each output byte goes through the command queue, then the output register.
module smtp_data_transparency_encoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sde_pkg::sde_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sde_pkg::sde_out_t out_data
);

  logic              push;
  sde_pkg::sde_cmd_t push_data;
  logic              full;
  logic              pop;
  sde_pkg::sde_cmd_t head;
  logic              empty;

  assign in_ready = !full;

  sde_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data)
  );

  sde_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  sde_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/sde_front.sv =====
module sde_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  sde_pkg::sde_in_t  in_data,
  output logic              push,
  output sde_pkg::sde_cmd_t push_data
);

  sde_pkg::line_mode_t line_mode, line_mode_next;
  logic [2:0]          match_count, match_count_next;
  sde_pkg::sde_cmd_t   cmd;
  logic                accept;
  logic [2:0]          m;
  logic                is_lf;

  assign accept = in_valid && in_ready;
  assign m      = sde_pkg::held_count(match_count);
  assign is_lf  = (in_data.data_byte == sde_pkg::CH_LF);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_mode   <= sde_pkg::LM_START;
      match_count <= 3'd1;
    end else if (accept) begin
      line_mode   <= line_mode_next;
      match_count <= match_count_next;
    end
  end

  always_comb begin
    line_mode_next   = line_mode;
    match_count_next = 3'd1;
    cmd.held         = 3'd0;
    cmd.tail         = sde_pkg::TAIL_NONE;
    cmd.data         = in_data.data_byte;
    if (in_data.req_type == sde_pkg::REQ_EOM) begin
      if (line_mode == sde_pkg::LM_KEY) cmd.held = m;
      if (line_mode != sde_pkg::LM_START) cmd.tail = sde_pkg::TAIL_CRLF;
      line_mode_next = sde_pkg::LM_START;
    end else begin
      case (line_mode)
        sde_pkg::LM_START: begin
          if (is_lf) begin
            cmd.tail = sde_pkg::TAIL_CRLF;
          end else if (in_data.data_byte == sde_pkg::CH_DOT) begin
            cmd.tail       = sde_pkg::TAIL_DOTS;
            line_mode_next = sde_pkg::LM_MIDDLE;
          end else if (in_data.data_byte == sde_pkg::key_char(3'd0)) begin
            line_mode_next = sde_pkg::LM_KEY;
          end else begin
            cmd.tail       = sde_pkg::TAIL_BYTE;
            line_mode_next = sde_pkg::LM_MIDDLE;
          end
        end
        sde_pkg::LM_KEY: begin
          if (in_data.data_byte == sde_pkg::key_char(m)) begin
            if (m == sde_pkg::KEY_HELD_MAX) begin
              cmd.tail       = sde_pkg::TAIL_FROM;
              line_mode_next = sde_pkg::LM_MIDDLE;
            end else begin
              match_count_next = m + 3'd1;
            end
          end else begin
            // broken prefix: flush it, then the byte itself
            cmd.held = m;
            if (is_lf) begin
              cmd.tail       = sde_pkg::TAIL_CRLF;
              line_mode_next = sde_pkg::LM_START;
            end else begin
              cmd.tail       = sde_pkg::TAIL_BYTE;
              line_mode_next = sde_pkg::LM_MIDDLE;
            end
          end
        end
        default: begin
          if (is_lf) begin
            cmd.tail       = sde_pkg::TAIL_CRLF;
            line_mode_next = sde_pkg::LM_START;
          end else begin
            cmd.tail       = sde_pkg::TAIL_BYTE;
            line_mode_next = sde_pkg::LM_MIDDLE;
          end
        end
      endcase
    end
  end

  // transactions that produce no bytes never enter the queue
  assign push      = accept && (sde_pkg::cmd_len(cmd) != 3'd0);
  assign push_data = cmd;

endmodule

// ===== src/sde_fifo.sv =====
module sde_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sde_pkg::sde_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output sde_pkg::sde_cmd_t head,
  output logic              empty
);

  sde_pkg::sde_cmd_t                mem [sde_pkg::QDEPTH];
  logic [sde_pkg::QPTR_W-1:0]       wr_ptr;
  logic [sde_pkg::QPTR_W-1:0]       rd_ptr;
  logic [sde_pkg::QCNT_W-1:0]       count;
  logic                             do_push;
  logic                             do_pop;

  assign full    = (count == sde_pkg::QCNT_W'(sde_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/sde_back.sv =====
module sde_back (
  input  logic               clk,
  input  logic               rst,
  input  sde_pkg::sde_cmd_t  head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output sde_pkg::sde_out_t  out_data
);

  logic [2:0] idx;
  logic       emit;
  logic       is_last;

  assign emit    = !empty && (!out_valid || out_ready);
  assign is_last = (idx == sde_pkg::cmd_len(head) - 3'd1);
  assign pop     = emit && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (emit) begin
      out_valid <= 1'b1;
      idx       <= is_last ? 3'd0 : idx + 3'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.out_byte <= sde_pkg::cmd_byte(head, idx);
      out_data.last     <= is_last;
    end
  end

endmodule

// ===== src/sde_checker.sv =====
module sde_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input sde_pkg::sde_out_t out_data
);

  // a stalled output byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready right after reset");

  // bytes of one transaction go out back to back
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last |=> out_valid)
    else $error("gap inside an output burst");

  // a CR that is not a transaction's last byte is followed by its LF
  a_crlf: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.out_byte == sde_pkg::CH_CR && !out_data.last
      |=> out_data.out_byte == sde_pkg::CH_LF)
    else $error("CR not followed by LF");

endmodule

bind smtp_data_transparency_encoder sde_checker u_sde_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
